// ===== rtl/core/hjc_pkg.sv =====
// Shared types, register codes and reset values of the headset jack classifier.
package hjc_pkg;

  localparam int ADC_BITS       = 12;
  localparam int TIMER_BITS_DEF = 16;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_HIGH_THR    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FOUR_THR    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNSTABLE    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ABN_LIMIT   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LOW_LIMIT   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_INS_DELAY   = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RETRY       = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SHORT_KEY   = 3'd7;

  // Register reset values.
  localparam logic [ADC_BITS-1:0] HIGH_THR_RST  = 12'd3250;
  localparam logic [ADC_BITS-1:0] FOUR_THR_RST  = 12'd800;
  localparam logic [ADC_BITS-1:0] UNSTABLE_RST  = 12'd400;
  localparam logic [7:0]          ABN_LIMIT_RST = 8'd100;
  localparam logic [3:0]          LOW_LIMIT_RST = 4'd10;
  localparam logic [15:0]         INS_DELAY_RST = 16'd450;
  localparam logic [15:0]         RETRY_RST     = 16'd10;
  localparam logic [15:0]         SHORT_KEY_RST = 16'd120;

  // Plug type codes.
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_THREE = 2'd1;
  localparam logic [1:0] KIND_FOUR  = 2'd2;

  // Key event codes.
  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_PRESS   = 2'd1;
  localparam logic [1:0] EV_RELEASE = 2'd2;

  typedef struct packed {
    logic [ADC_BITS-1:0] high_threshold;
    logic [ADC_BITS-1:0] four_pole_threshold;
    logic [ADC_BITS-1:0] unstable_threshold;
    logic [7:0]          abnormal_limit;
    logic [3:0]          low_retry_limit;
    logic [15:0]         insert_delay;
    logic [15:0]         retry_interval;
    logic [15:0]         short_key_ticks;
  } cfg_t;

  typedef struct packed {
    logic                jack_present;
    logic                button_level;
    logic [ADC_BITS-1:0] adc_sample;
  } item_t;

  typedef struct packed {
    logic [1:0] jack_type;
    logic       bias_on;
    logic [1:0] key_event;
    logic       key_enabled;
  } result_t;

endpackage

// ===== rtl/core/hjc_if.sv =====
// Handshake interfaces for the tick input channel and the result channel.
interface hjc_in_if;
  logic                        valid;
  logic                        ready;
  logic                        jack_present;
  logic                        button_level;
  logic [hjc_pkg::ADC_BITS-1:0] adc_sample;

  modport source (output valid, jack_present, button_level, adc_sample, input ready);
  modport sink   (input valid, jack_present, button_level, adc_sample, output ready);
endinterface

interface hjc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] jack_type;
  logic       bias_on;
  logic [1:0] key_event;
  logic       key_enabled;

  modport source (output valid, jack_type, bias_on, key_event, key_enabled, input ready);
  modport sink   (input valid, jack_type, bias_on, key_event, key_enabled, output ready);
endinterface

// ===== rtl/core/hjc_cfg_regs.sv =====
// Configuration register file of the headset jack classifier.
module hjc_cfg_regs (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [hjc_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [hjc_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,
  output hjc_pkg::cfg_t                        cfg
);
  import hjc_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.high_threshold      <= HIGH_THR_RST;
      cfg_r.four_pole_threshold <= FOUR_THR_RST;
      cfg_r.unstable_threshold  <= UNSTABLE_RST;
      cfg_r.abnormal_limit      <= ABN_LIMIT_RST;
      cfg_r.low_retry_limit     <= LOW_LIMIT_RST;
      cfg_r.insert_delay        <= INS_DELAY_RST;
      cfg_r.retry_interval      <= RETRY_RST;
      cfg_r.short_key_ticks     <= SHORT_KEY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HIGH_THR:  cfg_r.high_threshold      <= cfg_wdata[ADC_BITS-1:0];
        CFG_FOUR_THR:  cfg_r.four_pole_threshold <= cfg_wdata[ADC_BITS-1:0];
        CFG_UNSTABLE:  cfg_r.unstable_threshold  <= cfg_wdata[ADC_BITS-1:0];
        CFG_ABN_LIMIT: cfg_r.abnormal_limit      <= cfg_wdata[7:0];
        CFG_LOW_LIMIT: cfg_r.low_retry_limit     <= cfg_wdata[3:0];
        CFG_INS_DELAY: cfg_r.insert_delay        <= cfg_wdata[15:0];
        CFG_RETRY:     cfg_r.retry_interval      <= cfg_wdata[15:0];
        CFG_SHORT_KEY: cfg_r.short_key_ticks     <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/core/hjc_step.sv =====
// Per-tick classification and button state machine, with its state registers.
module hjc_step #(
  parameter int TIMER_BITS = hjc_pkg::TIMER_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_en,
  input  hjc_pkg::cfg_t    cfg,
  input  hjc_pkg::item_t   item,
  output hjc_pkg::result_t result
);
  import hjc_pkg::*;

  // Width that holds every value before saturation to the timer width.
  localparam int WW = ((TIMER_BITS > 16) ? TIMER_BITS : 16) + 1;
  localparam logic [WW-1:0] TMAX_W = WW'({TIMER_BITS{1'b1}});

  localparam logic [1:0] PH_IDLE     = 2'd0;
  localparam logic [1:0] PH_WAIT     = 2'd1;
  localparam logic [1:0] PH_CLASSIFY = 2'd2;
  localparam logic [1:0] PH_DONE     = 2'd3;

  function automatic logic [TIMER_BITS-1:0] cap(input logic [WW-1:0] v);
    logic [TIMER_BITS-1:0] r;
    if (v > TMAX_W) begin
      r = {TIMER_BITS{1'b1}};
    end else begin
      r = v[TIMER_BITS-1:0];
    end
    return r;
  endfunction

  logic [1:0]            phase_r, phase_nxt;
  logic [TIMER_BITS-1:0] wait_r, wait_nxt;
  logic [7:0]            abn_r, abn_nxt;
  logic [3:0]            low_r, low_nxt;
  logic [1:0]            kind_r, kind_nxt;
  logic                  armed_r, armed_nxt;
  logic                  press_pend_r, press_pend_nxt;
  logic                  rel_pend_r, rel_pend_nxt;
  logic [TIMER_BITS-1:0] key_timer_r, key_timer_nxt;
  logic [TIMER_BITS-1:0] press_age_r, press_age_nxt;
  logic                  key_down_r, key_down_nxt;
  logic                  prev_btn_r;

  logic [1:0]            event_c;
  logic                  do_sample;
  logic                  rise;
  logic                  fall;
  logic [TIMER_BITS-1:0] short_t;

  assign short_t = cap(WW'(cfg.short_key_ticks));
  assign rise    = item.button_level && !prev_btn_r;
  assign fall    = !item.button_level && prev_btn_r;

  always_comb begin
    phase_nxt      = phase_r;
    wait_nxt       = wait_r;
    abn_nxt        = abn_r;
    low_nxt        = low_r;
    kind_nxt       = kind_r;
    armed_nxt      = armed_r;
    press_pend_nxt = press_pend_r;
    rel_pend_nxt   = rel_pend_r;
    key_timer_nxt  = key_timer_r;
    press_age_nxt  = press_age_r;
    key_down_nxt   = key_down_r;
    event_c        = EV_NONE;
    do_sample      = 1'b0;

    if (!item.jack_present) begin
      // Removal clears everything and closes out a reported press.
      if (key_down_r) begin
        event_c = EV_RELEASE;
      end
      phase_nxt      = PH_IDLE;
      wait_nxt       = '0;
      abn_nxt        = '0;
      low_nxt        = '0;
      kind_nxt       = KIND_NONE;
      armed_nxt      = 1'b0;
      press_pend_nxt = 1'b0;
      rel_pend_nxt   = 1'b0;
      key_timer_nxt  = '0;
      press_age_nxt  = '0;
      key_down_nxt   = 1'b0;
    end else begin
      if (phase_nxt == PH_IDLE) begin
        phase_nxt = PH_WAIT;
        wait_nxt  = '0;
        abn_nxt   = '0;
        low_nxt   = '0;
        kind_nxt  = KIND_NONE;
      end

      if (phase_nxt == PH_WAIT) begin
        if (wait_nxt >= cap(WW'(cfg.insert_delay))) begin
          phase_nxt = PH_CLASSIFY;
          wait_nxt  = '0;
          do_sample = 1'b1;
        end else begin
          wait_nxt = cap(WW'(wait_nxt) + WW'(1));
        end
      end else if (phase_nxt == PH_CLASSIFY) begin
        if (wait_nxt != '0) begin
          wait_nxt = wait_nxt - TIMER_BITS'(1);
        end
        do_sample = (wait_nxt == '0);
      end

      if (do_sample) begin
        if (item.adc_sample > cfg.high_threshold) begin
          if (abn_nxt > cfg.abnormal_limit) begin
            kind_nxt  = KIND_THREE;
            armed_nxt = 1'b0;
            abn_nxt   = '0;
            low_nxt   = '0;
            phase_nxt = PH_DONE;
          end else begin
            if (abn_nxt != 8'hFF) begin
              abn_nxt = abn_nxt + 8'd1;
            end
            wait_nxt = cap(WW'(cfg.retry_interval));
          end
        end else if (item.adc_sample > cfg.four_pole_threshold) begin
          kind_nxt  = KIND_FOUR;
          armed_nxt = 1'b1;
          phase_nxt = PH_DONE;
        end else if (item.adc_sample > cfg.unstable_threshold) begin
          phase_nxt = PH_DONE;
        end else if (item.adc_sample == '0 || low_nxt >= cfg.low_retry_limit) begin
          kind_nxt  = KIND_THREE;
          armed_nxt = 1'b0;
          low_nxt   = '0;
          phase_nxt = PH_DONE;
        end else begin
          if (low_nxt != 4'hF) begin
            low_nxt = low_nxt + 4'd1;
          end
          wait_nxt = cap(WW'({cfg.retry_interval, 1'b0}));
        end
      end

      if (armed_nxt) begin
        if (rise) begin
          if (rel_pend_nxt) begin
            event_c       = EV_RELEASE;
            rel_pend_nxt  = 1'b0;
            key_down_nxt  = 1'b0;
            key_timer_nxt = '0;
          end
          press_pend_nxt = 1'b1;
          press_age_nxt  = '0;
        end else if (fall) begin
          if (press_pend_nxt) begin
            press_pend_nxt = 1'b0;
          end else if (key_down_nxt && !rel_pend_nxt) begin
            rel_pend_nxt  = 1'b1;
            key_timer_nxt = short_t;
          end
        end else if (item.button_level && press_pend_nxt) begin
          press_age_nxt = cap(WW'(press_age_nxt) + WW'(1));
        end

        if (press_pend_nxt && press_age_nxt >= short_t && event_c == EV_NONE) begin
          press_pend_nxt = 1'b0;
          key_down_nxt   = 1'b1;
          event_c        = EV_PRESS;
        end

        if (rel_pend_nxt && event_c == EV_NONE) begin
          if (key_timer_nxt == '0) begin
            rel_pend_nxt = 1'b0;
            key_down_nxt = 1'b0;
            event_c      = EV_RELEASE;
          end else begin
            key_timer_nxt = key_timer_nxt - TIMER_BITS'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      wait_r       <= '0;
      abn_r        <= '0;
      low_r        <= '0;
      kind_r       <= KIND_NONE;
      armed_r      <= 1'b0;
      press_pend_r <= 1'b0;
      rel_pend_r   <= 1'b0;
      key_timer_r  <= '0;
      press_age_r  <= '0;
      key_down_r   <= 1'b0;
      prev_btn_r   <= 1'b0;
    end else if (step_en) begin
      phase_r      <= phase_nxt;
      wait_r       <= wait_nxt;
      abn_r        <= abn_nxt;
      low_r        <= low_nxt;
      kind_r       <= kind_nxt;
      armed_r      <= armed_nxt;
      press_pend_r <= press_pend_nxt;
      rel_pend_r   <= rel_pend_nxt;
      key_timer_r  <= key_timer_nxt;
      press_age_r  <= press_age_nxt;
      key_down_r   <= key_down_nxt;
      prev_btn_r   <= item.button_level;
    end
  end

  assign result.jack_type   = kind_nxt;
  assign result.bias_on     = (phase_nxt == PH_CLASSIFY) || (phase_nxt == PH_DONE);
  assign result.key_event   = event_c;
  assign result.key_enabled = armed_nxt;

endmodule

// ===== rtl/core/headset_jack_classifier_unit.sv =====
// Top level of the headset jack classifier: input register, tick logic, result register.
//
//  Channel   Direction  Handshake        Payload
//  in_ch     sink       valid / ready    jack_present, button_level, adc_sample
//  out_ch    source     valid / ready    jack_type, bias_on, key_event, key_enabled
//  cfg_*     sink       cfg_we only      cfg_index (3 bits), cfg_wdata (16 bits)
//
// One tick transaction is accepted per cycle while the result side is not stalled,
// and gives one result transaction: the tick is held in the input register, then
// passes through the tick logic into the result register. Throughput is set by the
// single state update per tick. Reset is synchronous and active low; it clears both
// pipeline valids, the classifier state and restores the register reset values.
// When the result register holds an untaken result, the input register keeps
// its tick and in_ch.ready drops only once both registers are full.
module headset_jack_classifier_unit #(
  parameter int TIMER_BITS = hjc_pkg::TIMER_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  hjc_in_if.sink                             in_ch,
  hjc_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [hjc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [hjc_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);
  import hjc_pkg::*;

  cfg_t    cfg;
  item_t   in_item_r;
  logic    in_v_r;
  result_t step_res;
  result_t out_res_r;
  logic    out_v_r;
  logic    advance;

  // The tick in the input register moves on when the result register is free
  // or is being emptied in this cycle.
  assign advance     = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !in_v_r || advance;

  hjc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  hjc_step #(
    .TIMER_BITS (TIMER_BITS)
  ) u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .cfg     (cfg),
    .item    (in_item_r),
    .result  (step_res)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_v_r <= 1'b1;
    end else if (advance) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_item_r.jack_present <= in_ch.jack_present;
      in_item_r.button_level <= in_ch.button_level;
      in_item_r.adc_sample   <= in_ch.adc_sample;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= step_res;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.jack_type   = out_res_r.jack_type;
  assign out_ch.bias_on     = out_res_r.bias_on;
  assign out_ch.key_event   = out_res_r.key_event;
  assign out_ch.key_enabled = out_res_r.key_enabled;

  // A press can only be reported while the button is armed.
  a_press_needs_arm: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_res_r.key_event == EV_PRESS |-> out_res_r.key_enabled)
    else $error("key press reported while button not armed");

  // Arming the button goes only with a four-pole plug.
  a_arm_is_four_pole: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_res_r.key_enabled |-> out_res_r.jack_type == KIND_FOUR)
    else $error("button armed without a four-pole plug");

  // No plug type is known before mic bias comes on.
  a_type_after_bias: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_res_r.bias_on |-> out_res_r.jack_type == KIND_NONE)
    else $error("plug type reported with bias off");

  // A tick held in the input register is not lost while the output stalls.
  a_in_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !advance |=> in_v_r)
    else $error("input tick dropped during stall");

endmodule

// ===== tb/hjc_result_checker.sv =====
// Checker for the headset jack classifier: tracks ticks, predicts results and compares them.
module hjc_result_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  hjc_in_if                                 tick_ch,
  hjc_out_if                                res_ch,
  input  logic                              cfg_we,
  input  logic [hjc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [hjc_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
  output int                                mismatch_count,
  output int                                results_owed
);
  timeunit 1ns;
  timeprecision 1ps;
  import hjc_pkg::*;

  typedef enum logic [1:0] {DET_IDLE, DET_INSERT_WAIT, DET_CLASSIFY, DET_DONE} det_phase_t;

  cfg_t        regs;
  det_phase_t  det_phase;
  logic [15:0] settle_cnt;
  logic [7:0]  abnormal_cnt;
  logic [3:0]  low_cnt;
  logic [1:0]  plug_kind;
  logic        keys_armed;
  logic        press_waiting;
  logic        release_waiting;
  logic [15:0] release_timer;
  logic [15:0] hold_age;
  logic        key_held;
  logic        last_button;

  result_t predicted_results[$];
  int      fails = 0;

  assign mismatch_count = fails;
  assign results_owed   = predicted_results.size();

  function automatic void clear_detection();
    det_phase       = DET_IDLE;
    settle_cnt      = '0;
    abnormal_cnt    = '0;
    low_cnt         = '0;
    plug_kind       = KIND_NONE;
    keys_armed      = 1'b0;
    press_waiting   = 1'b0;
    release_waiting = 1'b0;
    release_timer   = '0;
    hold_age        = '0;
    key_held        = 1'b0;
  endfunction

  function automatic void apply_register(logic [CFG_IDX_BITS-1:0] idx,
                                         logic [CFG_DATA_BITS-1:0] data);
    case (idx)
      CFG_HIGH_THR:  regs.high_threshold      = data[ADC_BITS-1:0];
      CFG_FOUR_THR:  regs.four_pole_threshold = data[ADC_BITS-1:0];
      CFG_UNSTABLE:  regs.unstable_threshold  = data[ADC_BITS-1:0];
      CFG_ABN_LIMIT: regs.abnormal_limit      = data[7:0];
      CFG_LOW_LIMIT: regs.low_retry_limit     = data[3:0];
      CFG_INS_DELAY: regs.insert_delay        = data[15:0];
      CFG_RETRY:     regs.retry_interval      = data[15:0];
      CFG_SHORT_KEY: regs.short_key_ticks     = data[15:0];
      default: ;
    endcase
  endfunction

  // One ADC reading during classification.
  function automatic void judge_sample(logic [ADC_BITS-1:0] adc);
    logic [16:0] low_wait;
    low_wait = {regs.retry_interval, 1'b0};
    if (adc > regs.high_threshold) begin
      if (abnormal_cnt > regs.abnormal_limit) begin
        plug_kind    = KIND_THREE;
        keys_armed   = 1'b0;
        abnormal_cnt = '0;
        low_cnt      = '0;
        det_phase    = DET_DONE;
      end else begin
        if (abnormal_cnt != 8'hFF) abnormal_cnt++;
        settle_cnt = regs.retry_interval;
      end
    end else if (adc > regs.four_pole_threshold) begin
      plug_kind  = KIND_FOUR;
      keys_armed = 1'b1;
      det_phase  = DET_DONE;
    end else if (adc > regs.unstable_threshold) begin
      det_phase = DET_DONE;
    end else if (adc == '0 || low_cnt >= regs.low_retry_limit) begin
      plug_kind  = KIND_THREE;
      keys_armed = 1'b0;
      low_cnt    = '0;
      det_phase  = DET_DONE;
    end else begin
      if (low_cnt != 4'hF) low_cnt++;
      settle_cnt = low_wait[16] ? 16'hFFFF : low_wait[15:0];
    end
  endfunction

  function automatic result_t predict_tick(item_t t);
    logic [1:0] ev;
    logic       rise;
    logic       fall;
    result_t    r;
    ev = EV_NONE;
    if (!t.jack_present) begin
      if (key_held) ev = EV_RELEASE;
      clear_detection();
    end else begin
      if (det_phase == DET_IDLE) begin
        det_phase    = DET_INSERT_WAIT;
        settle_cnt   = '0;
        abnormal_cnt = '0;
        low_cnt      = '0;
        plug_kind    = KIND_NONE;
      end
      if (det_phase == DET_INSERT_WAIT) begin
        if (settle_cnt >= regs.insert_delay) begin
          det_phase  = DET_CLASSIFY;
          settle_cnt = '0;
          judge_sample(t.adc_sample);
        end else begin
          settle_cnt++;
        end
      end else if (det_phase == DET_CLASSIFY) begin
        if (settle_cnt != '0) settle_cnt--;
        if (settle_cnt == '0) judge_sample(t.adc_sample);
      end

      if (keys_armed) begin
        rise = t.button_level && !last_button;
        fall = !t.button_level && last_button;
        if (rise) begin
          if (release_waiting) begin
            ev              = EV_RELEASE;
            release_waiting = 1'b0;
            key_held        = 1'b0;
            release_timer   = '0;
          end
          press_waiting = 1'b1;
          hold_age      = '0;
        end else if (fall) begin
          if (press_waiting) begin
            press_waiting = 1'b0;
          end else if (key_held && !release_waiting) begin
            release_waiting = 1'b1;
            release_timer   = regs.short_key_ticks;
          end
        end else if (t.button_level && press_waiting) begin
          if (hold_age != 16'hFFFF) hold_age++;
        end

        if (press_waiting && hold_age >= regs.short_key_ticks && ev == EV_NONE) begin
          press_waiting = 1'b0;
          key_held      = 1'b1;
          ev            = EV_PRESS;
        end

        if (release_waiting && ev == EV_NONE) begin
          if (release_timer == '0) begin
            release_waiting = 1'b0;
            key_held        = 1'b0;
            ev              = EV_RELEASE;
          end else begin
            release_timer--;
          end
        end
      end
    end
    last_button   = t.button_level;
    r.jack_type   = plug_kind;
    r.bias_on     = (det_phase == DET_CLASSIFY || det_phase == DET_DONE);
    r.key_event   = ev;
    r.key_enabled = keys_armed;
    return r;
  endfunction

  task automatic check_field(string field, int want, int seen);
    if (want != seen) begin
      $error("%s: expected %0d, actual %0d", field, want, seen);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    item_t   tick;
    if (!rst_n) begin
      regs.high_threshold      = HIGH_THR_RST;
      regs.four_pole_threshold = FOUR_THR_RST;
      regs.unstable_threshold  = UNSTABLE_RST;
      regs.abnormal_limit      = ABN_LIMIT_RST;
      regs.low_retry_limit     = LOW_LIMIT_RST;
      regs.insert_delay        = INS_DELAY_RST;
      regs.retry_interval      = RETRY_RST;
      regs.short_key_ticks     = SHORT_KEY_RST;
      clear_detection();
      last_button = 1'b0;
      predicted_results.delete();
    end else begin
      if (cfg_we) apply_register(cfg_index, cfg_wdata);

      if (res_ch.valid && res_ch.ready) begin
        if (predicted_results.size() == 0) begin
          $error("result transaction arrived with no expected result waiting");
          fails++;
        end else begin
          want = predicted_results.pop_front();
          check_field("jack_type", want.jack_type, res_ch.jack_type);
          check_field("bias_on", want.bias_on, res_ch.bias_on);
          check_field("key_event", want.key_event, res_ch.key_event);
          check_field("key_enabled", want.key_enabled, res_ch.key_enabled);
        end
      end

      if (tick_ch.valid && tick_ch.ready) begin
        tick.jack_present = tick_ch.jack_present;
        tick.button_level = tick_ch.button_level;
        tick.adc_sample   = tick_ch.adc_sample;
        predicted_results.push_back(predict_tick(tick));
      end
    end
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the headset jack classifier testbench: clock, reset, stimulus and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import hjc_pkg::*;

  // ADC zones that an insertion episode aims its readings at.
  typedef enum int {ZONE_HIGH, ZONE_FOUR, ZONE_UNSTABLE, ZONE_LOW, ZONE_ZERO, ZONE_ANY} adc_zone_t;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;
  int                       mismatch_count;
  int                       results_owed;

  hjc_in_if  tick_ch();
  hjc_out_if res_ch();

  headset_jack_classifier_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (tick_ch),
    .out_ch    (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // The checker watches both channels and the register port on its own; this
  // module only generates traffic and reads back the failure and owed-result counts.
  hjc_result_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .tick_ch        (tick_ch),
    .res_ch         (res_ch),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  // Copy of the register settings currently programmed, used to aim ADC values
  // at particular zones and to size insertion episodes.
  cfg_t active_cfg;
  int   ticks_sent = 0;
  int   in_steady_left = 0;
  int   out_steady_left = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case the design hangs on a handshake.
  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Idle length between transactions. Most gaps are short, a few are long, and
  // now and then a run of back-to-back transactions with no idling at all.
  function automatic int pick_idle(ref int steady_left);
    int r;
    if (steady_left > 0) begin
      steady_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      steady_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // The result side stalls independently of the tick side. Since the block holds
  // at most two ticks in flight, long stalls here also push back on the tick channel.
  initial begin
    int stall;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      res_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      stall = pick_idle(out_steady_left);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Send one tick transaction and return once it has been accepted. Valid stays
  // high afterwards so that the next tick can follow without a bubble.
  task automatic send_tick(input logic jack, input logic button, input logic [ADC_BITS-1:0] adc);
    int gap;
    gap = pick_idle(in_steady_left);
    if (gap > 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_ch.valid        <= 1'b1;
    tick_ch.jack_present <= jack;
    tick_ch.button_level <= button;
    tick_ch.adc_sample   <= adc;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
    ticks_sent++;
  endtask

  // Stop sending and wait until every result has come back. Every tick yields
  // exactly one result, so an empty expectation store means the block is idle.
  // It first drops valid and waits on the clock so that the last accepted tick is counted.
  task automatic drain_results();
    tick_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all eight registers. The unused upper bits of the narrow registers
  // carry random junk, which the block must drop.
  task automatic program_settings(input cfg_t s);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_HIGH_THR;
    cfg_wdata <= {4'($urandom), s.high_threshold};
    @(posedge clk);
    cfg_index <= CFG_FOUR_THR;
    cfg_wdata <= {4'($urandom), s.four_pole_threshold};
    @(posedge clk);
    cfg_index <= CFG_UNSTABLE;
    cfg_wdata <= {4'($urandom), s.unstable_threshold};
    @(posedge clk);
    cfg_index <= CFG_ABN_LIMIT;
    cfg_wdata <= {8'($urandom), s.abnormal_limit};
    @(posedge clk);
    cfg_index <= CFG_LOW_LIMIT;
    cfg_wdata <= {12'($urandom), s.low_retry_limit};
    @(posedge clk);
    cfg_index <= CFG_INS_DELAY;
    cfg_wdata <= s.insert_delay;
    @(posedge clk);
    cfg_index <= CFG_RETRY;
    cfg_wdata <= s.retry_interval;
    @(posedge clk);
    cfg_index <= CFG_SHORT_KEY;
    cfg_wdata <= s.short_key_ticks;
    @(posedge clk);
    cfg_we <= 1'b0;
    active_cfg = s;
  endtask

  // Random settings with short timing so that insertions reach classification
  // and button handling quickly. Thresholds are either ordered as a real
  // headset would need or thrown together in any order.
  function automatic cfg_t random_settings(bit ordered);
    cfg_t              s;
    logic [ADC_BITS-1:0] v0;
    logic [ADC_BITS-1:0] v1;
    logic [ADC_BITS-1:0] v2;
    logic [ADC_BITS-1:0] t;
    v0 = ADC_BITS'($urandom_range(0, 4095));
    v1 = ADC_BITS'($urandom_range(0, 4095));
    v2 = ADC_BITS'($urandom_range(0, 4095));
    if (ordered) begin
      if (v0 > v1) begin t = v0; v0 = v1; v1 = t; end
      if (v1 > v2) begin t = v1; v1 = v2; v2 = t; end
      if (v0 > v1) begin t = v0; v0 = v1; v1 = t; end
    end
    s.unstable_threshold  = v0;
    s.four_pole_threshold = v1;
    s.high_threshold      = v2;
    s.abnormal_limit      = 8'($urandom_range(0, 4));
    s.low_retry_limit     = 4'($urandom_range(0, 4));
    s.insert_delay        = 16'($urandom_range(0, 5));
    s.retry_interval      = 16'($urandom_range(1, 3));
    s.short_key_ticks     = 16'($urandom_range(1, 4));
    return s;
  endfunction

  // An ADC reading inside the chosen zone for the current thresholds. A zone
  // that the thresholds leave empty falls back to the full range.
  function automatic logic [ADC_BITS-1:0] zone_sample(adc_zone_t zone);
    int lo;
    int hi;
    case (zone)
      ZONE_HIGH: begin
        lo = active_cfg.high_threshold + 1;
        hi = 4095;
      end
      ZONE_FOUR: begin
        lo = active_cfg.four_pole_threshold + 1;
        hi = active_cfg.high_threshold;
      end
      ZONE_UNSTABLE: begin
        lo = active_cfg.unstable_threshold + 1;
        hi = active_cfg.four_pole_threshold;
      end
      ZONE_LOW: begin
        lo = 1;
        hi = active_cfg.unstable_threshold;
      end
      ZONE_ZERO: begin
        lo = 0;
        hi = 0;
      end
      default: begin
        lo = 0;
        hi = 4095;
      end
    endcase
    if (lo > hi) begin
      lo = 0;
      hi = 4095;
    end
    return ADC_BITS'($urandom_range(hi, lo));
  endfunction

  // Four-pole plugs are favored because only they arm the button logic.
  function automatic adc_zone_t pick_zone();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return ZONE_FOUR;
    if (r == 4) return ZONE_HIGH;
    if (r == 5) return ZONE_UNSTABLE;
    if (r == 6) return ZONE_LOW;
    if (r == 7) return ZONE_ZERO;
    return ZONE_ANY;
  endfunction

  // One plug session: a short unplugged stretch of noise, then the jack held in
  // long enough to get through the insertion delay and classification, with
  // button activity whose hold times straddle the press threshold. Readings
  // sometimes drift into another zone, and the jack occasionally bounces out.
  task automatic run_episode();
    adc_zone_t zone;
    int        on_len;
    int        k;
    int        btn_left;
    logic      btn;
    logic      jack;
    repeat ($urandom_range(1, 3)) send_tick(1'b0, 1'($urandom), 12'($urandom));
    zone     = pick_zone();
    on_len   = active_cfg.insert_delay + $urandom_range(3, 25);
    btn      = 1'($urandom);
    btn_left = $urandom_range(0, 3);
    for (k = 0; k < on_len; k++) begin
      if (btn_left == 0) begin
        btn      = ~btn;
        btn_left = $urandom_range(1, active_cfg.short_key_ticks + 3);
      end
      btn_left--;
      if ($urandom_range(0, 9) == 0) zone = pick_zone();
      jack = ($urandom_range(0, 29) != 0);
      send_tick(jack, btn, zone_sample(zone));
    end
  endtask

  initial begin
    cfg_t s;
    int   phase_start;
    int   spin;

    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_index            <= CFG_HIGH_THR;
    cfg_wdata            <= '0;
    tick_ch.valid        <= 1'b0;
    tick_ch.jack_present <= 1'b0;
    tick_ch.button_level <= 1'b0;
    tick_ch.adc_sample   <= '0;
    active_cfg.high_threshold      = HIGH_THR_RST;
    active_cfg.four_pole_threshold = FOUR_THR_RST;
    active_cfg.unstable_threshold  = UNSTABLE_RST;
    active_cfg.abnormal_limit      = ABN_LIMIT_RST;
    active_cfg.low_retry_limit     = LOW_LIMIT_RST;
    active_cfg.insert_delay        = INS_DELAY_RST;
    active_cfg.retry_interval      = RETRY_RST;
    active_cfg.short_key_ticks     = SHORT_KEY_RST;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Under the reset settings the jack is already present on the
    // first tick, which must count as a fresh insertion; the button is ignored
    // because nothing is armed yet.
    send_tick(1'b1, 1'b1, 12'hFFF);
    send_tick(1'b0, 1'b0, 12'h000);
    drain_results();

    // Zero insertion delay and zero retry wait: the plug is sampled on the
    // insertion tick and then on every following tick until it is classified.
    s.high_threshold      = 12'd3000;
    s.four_pole_threshold = 12'd1500;
    s.unstable_threshold  = 12'd500;
    s.abnormal_limit      = 8'd2;
    s.low_retry_limit     = 4'd15;
    s.insert_delay        = 16'd0;
    s.retry_interval      = 16'd0;
    s.short_key_ticks     = 16'd2;
    program_settings(s);

    // Open line: high readings until the abnormal limit is passed, giving three-pole.
    repeat (4) send_tick(1'b1, 1'b0, 12'hFFF);
    send_tick(1'b0, 1'b1, 12'h000);
    // Four-pole plug, then a press long enough to be reported.
    send_tick(1'b1, 1'b0, 12'd2000);
    repeat (3) send_tick(1'b1, 1'b1, 12'd2000);
    // Let go, and press again while the release is still pending: the release is
    // reported on the new press.
    send_tick(1'b1, 1'b0, 12'd2000);
    send_tick(1'b1, 1'b1, 12'd2000);
    // Let go before the new press was reported: it is dropped silently.
    send_tick(1'b1, 1'b0, 12'd2000);
    // Button already down at insertion, then a release edge with nothing pending.
    send_tick(1'b0, 1'b1, 12'h000);
    send_tick(1'b1, 1'b1, 12'd2000);
    send_tick(1'b1, 1'b0, 12'd2000);
    // Reported press, then removal while held forces a release.
    repeat (3) send_tick(1'b1, 1'b1, 12'd2000);
    send_tick(1'b0, 1'b1, 12'd2000);
    // Low reading under the unstable threshold: a retry, no type, bias stays on.
    send_tick(1'b1, 1'b0, 12'd450);
    send_tick(1'b0, 1'b0, 12'd450);
    // Zero reading gives three-pole at once.
    send_tick(1'b1, 1'b0, 12'd0);
    send_tick(1'b0, 1'b0, 12'd0);
    // Build up low retries, then lower the retry limit beneath the count while
    // the plug stays in; the next low reading must declare three-pole.
    repeat (4) send_tick(1'b1, 1'b0, 12'd100);
    drain_results();
    s.low_retry_limit = 4'd2;
    program_settings(s);
    send_tick(1'b1, 1'b0, 12'd100);
    send_tick(1'b0, 1'b0, 12'd100);
    drain_results();

    // Random part: several settings, each with roughly twenty ticks of plug
    // sessions. One setting keeps the reset thresholds, one uses thresholds in
    // arbitrary order.
    for (int p = 0; p < 5; p++) begin
      s = random_settings(p != 3);
      if (p == 2) begin
        s.high_threshold      = HIGH_THR_RST;
        s.four_pole_threshold = FOUR_THR_RST;
        s.unstable_threshold  = UNSTABLE_RST;
      end
      program_settings(s);
      phase_start = ticks_sent;
      while (ticks_sent - phase_start < 20) run_episode();
      drain_results();
    end

    // All thresholds at zero with the largest abnormal limit: every nonzero
    // reading is high, the abnormal count saturates and the block keeps
    // retrying. A final zero reading falls through to three-pole.
    s.high_threshold      = 12'd0;
    s.four_pole_threshold = 12'd0;
    s.unstable_threshold  = 12'd0;
    s.abnormal_limit      = 8'd255;
    s.low_retry_limit     = 4'd0;
    s.insert_delay        = 16'd0;
    s.retry_interval      = 16'd1;
    s.short_key_ticks     = 16'd1;
    program_settings(s);
    send_tick(1'b0, 1'b0, 12'd0);
    repeat (260) send_tick(1'b1, 1'($urandom), 12'($urandom_range(1, 4095)));
    send_tick(1'b1, 1'b0, 12'd0);
    send_tick(1'b0, 1'b0, 12'd0);
    drain_results();

    // All thresholds at the top with the longest retry and key waits: readings land
    // in the low or zero zone and the doubled retry wait saturates.
    s.high_threshold      = 12'hFFF;
    s.four_pole_threshold = 12'hFFF;
    s.unstable_threshold  = 12'hFFF;
    s.abnormal_limit      = 8'd0;
    s.low_retry_limit     = 4'hF;
    s.insert_delay        = 16'd1;
    s.retry_interval      = 16'hFFFF;
    s.short_key_ticks     = 16'hFFFF;
    program_settings(s);
    run_episode();
    drain_results();

    // Longest insertion delay: the plug only waits.
    s = random_settings(1'b1);
    s.insert_delay = 16'hFFFF;
    program_settings(s);
    send_tick(1'b0, 1'b0, 12'd0);
    repeat (10) send_tick(1'b1, 1'($urandom), 12'($urandom));

    // Wind down: wait for the last results, bounded, then give the verdict.
    tick_ch.valid <= 1'b0;
    @(posedge clk);
    for (spin = 0; spin < 20000 && results_owed != 0; spin++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (results_owed != 0) $error("%0d expected results never arrived", results_owed);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== headset_jack_classifier_unit.f =====
rtl/core/hjc_pkg.sv
rtl/core/hjc_if.sv
rtl/core/hjc_cfg_regs.sv
rtl/core/hjc_step.sv
rtl/core/headset_jack_classifier_unit.sv
tb/hjc_result_checker.sv
tb/testbench.sv
